>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the downsampler checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define ASSERT_SAME(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while dis is high.
`define ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/mipds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipds_pkg
// Types and constants of the RGBA8 mip level box downsampler.
// ----------------------------------------------------------------------------
package mipds_pkg;

    localparam int CFG_W         = 13;
    localparam int CFG_IDX_W     = 1;
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int ROW_W         = 12;
    localparam int CH_W          = 8;
    localparam int PAIR_W        = CH_W + 1;
    localparam int LINE_W        = 4 * PAIR_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEVEL_WIDTH  = 1'b0,
        REG_LEVEL_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [CH_W-1:0] in_red;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_blue;
        logic [CH_W-1:0] in_alpha;
    } t_pixel_in;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_alpha;
        logic            level_done;
    } t_pixel_out;

endpackage

>>> hw/rtl/rgba8_mip_box_downsample.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgba8_mip_box_downsample
// Turns one RGBA8 mip level in raster order into the next level with a
// 2x2 truncating box filter, clamping odd edges to the last column or row.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// config    in         i_cfg_we           i_cfg_idx, i_cfg_data
// pixel in  in         i_valid / o_ready  i_data (t_pixel_in)
// pixel out out        o_valid / i_ready  o_data (t_pixel_out)
//
// One source pixel is taken every cycle while o_ready is high; a result is
// offered through the pipeline stage and output register after its 2x2 block.
// The line store is read on the accepting edge and its registered data is used
// in the stage that feeds the output register.
// Reset clears the counters and the valid flags; line contents need no clear.
// A stalled output holds one result in the output register and one in the
// pipeline stage before it; input is refused only when both are occupied and
// the output is not taken, or while i_rst_n is low.
// ----------------------------------------------------------------------------
module rgba8_mip_box_downsample #(
    parameter int MAX_WIDTH = mipds_pkg::MAX_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mipds_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mipds_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  mipds_pkg::t_pixel_in               i_data,
    output logic                               o_valid,
    input  logic                               i_ready,
    output mipds_pkg::t_pixel_out              o_data
);

    import mipds_pkg::*;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int EW         = (WW > CFG_W) ? WW : CFG_W;
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int LA         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    function automatic logic [CH_W-1:0] avg_ch(input logic odd_row,
                                               input logic [PAIR_W-1:0] above,
                                               input logic [PAIR_W-1:0] pair);
        logic [PAIR_W:0] sum;
        sum = {1'b0, above} + {1'b0, pair};
        return odd_row ? sum[PAIR_W:2] : pair[PAIR_W-1:1];
    endfunction

    logic [CFG_W-1:0]  r_width;
    logic [CFG_W-1:0]  r_height;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    t_pixel_in         r_held;
    logic              r_s2_valid;
    logic              r_s2_odd;
    logic              r_s2_done;
    logic [LINE_W-1:0] r_s2_pair;
    logic              r_out_valid;
    t_pixel_out        r_out;

    logic [EW-1:0]     eff_w;
    logic [CFG_W-1:0]  eff_h;
    logic [EW-1:0]     col_next;
    logic [CFG_W-1:0]  row_next;
    logic              last_col;
    logic              last_row;
    logic              pair_ready;
    logic              produce;
    logic              accept;
    logic              s2_move;
    t_pixel_in         partner;
    logic [LINE_W-1:0] pair_word;
    logic [LINE_W-1:0] above_word;
    logic              line_we;
    logic              line_re;
    logic [LA-1:0]     line_addr;
    t_pixel_out        n_out;

    always_comb begin
        if (EW'(r_width) == '0) begin
            eff_w = EW'(1);
        end else if (EW'(r_width) > EW'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = EW'(r_width);
        end
        if (r_height == '0) begin
            eff_h = CFG_W'(1);
        end else if (r_height > CFG_W'(MAX_HEIGHT)) begin
            eff_h = CFG_W'(MAX_HEIGHT);
        end else begin
            eff_h = r_height;
        end
    end

    assign col_next   = EW'(r_col) + EW'(1);
    assign row_next   = CFG_W'(r_row) + CFG_W'(1);
    assign last_col   = (col_next >= eff_w);
    assign last_row   = (row_next >= eff_h);
    assign pair_ready = r_col[0] || last_col;
    assign produce    = pair_ready && (r_row[0] || last_row);

    assign s2_move = r_s2_valid && (!r_out_valid || i_ready);
    assign o_ready = i_rst_n && (!r_s2_valid || s2_move);
    assign accept  = i_valid && o_ready;

    assign partner   = r_col[0] ? r_held : i_data;
    assign pair_word = {
        PAIR_W'(partner.in_red)   + PAIR_W'(i_data.in_red),
        PAIR_W'(partner.in_green) + PAIR_W'(i_data.in_green),
        PAIR_W'(partner.in_blue)  + PAIR_W'(i_data.in_blue),
        PAIR_W'(partner.in_alpha) + PAIR_W'(i_data.in_alpha)
    };

    assign line_we   = accept && pair_ready && !r_row[0] && !last_row;
    assign line_re   = accept && pair_ready && r_row[0];
    assign line_addr = LA'(r_col >> 1);

    mipds_line_ram #(
        .DEPTH (LINE_DEPTH),
        .AW    (LA),
        .DW    (LINE_W)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (line_addr),
        .i_wdata (pair_word),
        .i_re    (line_re),
        .i_raddr (line_addr),
        .o_rdata (above_word)
    );

    always_comb begin
        n_out.out_red    = avg_ch(r_s2_odd, above_word[4*PAIR_W-1:3*PAIR_W],
                                  r_s2_pair[4*PAIR_W-1:3*PAIR_W]);
        n_out.out_green  = avg_ch(r_s2_odd, above_word[3*PAIR_W-1:2*PAIR_W],
                                  r_s2_pair[3*PAIR_W-1:2*PAIR_W]);
        n_out.out_blue   = avg_ch(r_s2_odd, above_word[2*PAIR_W-1:PAIR_W],
                                  r_s2_pair[2*PAIR_W-1:PAIR_W]);
        n_out.out_alpha  = avg_ch(r_s2_odd, above_word[PAIR_W-1:0],
                                  r_s2_pair[PAIR_W-1:0]);
        n_out.level_done = r_s2_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W'(1);
            r_height <= CFG_W'(1);
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_LEVEL_WIDTH:  r_width  <= i_cfg_data;
                REG_LEVEL_HEIGHT: r_height <= i_cfg_data;
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : ROW_W'(row_next);
            end else begin
                r_col <= COL_W'(col_next);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !pair_ready) begin
            r_held <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (accept) begin
            r_s2_valid <= produce;
        end else if (s2_move) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s2_odd  <= r_row[0];
            r_s2_done <= last_col && last_row;
            r_s2_pair <= pair_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_move) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

>>> hw/rtl/mipds_line_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipds_line_ram
// Simple dual-port line store with one write port and a registered read port.
// ----------------------------------------------------------------------------
module mipds_line_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 36
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/mipds_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipds_checker
// Port-level checks of the downsampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mipds_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic                            o_valid,
    input logic                            i_ready,
    input mipds_pkg::t_pixel_out           o_data
);

    import mipds_pkg::*;

    `ASSERT_NEXT(a_reset_clears_out, i_clk, 1'b0, !i_rst_n, !o_valid)
    `ASSERT_NEXT(a_out_valid_holds, i_clk, !i_rst_n, o_valid && !i_ready, o_valid)
    `ASSERT_NEXT(a_out_data_holds, i_clk, !i_rst_n, o_valid && !i_ready, $stable(o_data))
    `ASSERT_SAME(a_out_from_input, i_clk, !i_rst_n, $rose(o_valid), $past(i_valid && o_ready, 2))

endmodule

bind rgba8_mip_box_downsample mipds_checker u_mipds_checker (.*);

>>> tb/rgba8_mip_box_downsample_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgba8_mip_box_downsample_test
// Self-checking bench for the RGBA8 2x2 box mip downsampler. Level sizes are
// programmed while the block is idle, then source pixels stream in under
// random source gaps and sink stalls. Every accepted source transaction runs
// through a bit-exact predictor of the block, and every accepted output
// transaction is compared field by field with the oldest predicted pixel.
// Stimulus starts with edge values and odd sizes, then mostly whole levels
// of random small sizes with some cut-off levels, and ends with one wide
// whole level and a few cut-off levels at the largest widths and heights.
// ----------------------------------------------------------------------------
module rgba8_mip_box_downsample_test;
    import mipds_pkg::*;

    localparam int LINE_DEPTH   = (MAX_WIDTH_DEF + 1) / 2;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_TICKS = 4;
    localparam int RANDOM_ITEMS = 660;

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned top);
        if (v == 0) return 1;
        if (v > top) return top;
        return 32'(v);
    endfunction

    class box_filter_board;
        t_pixel_out        pending_mip[$];
        logic [PAIR_W-1:0] pair_line [LINE_DEPTH][4];
        int unsigned       held [4];
        int unsigned       col;
        int unsigned       row;
        logic [CFG_W-1:0]  width_reg;
        logic [CFG_W-1:0]  height_reg;
        int                errors;
        int                pixels_in;
        int                pixels_out;

        function new();
            width_reg  = CFG_W'(1);
            height_reg = CFG_W'(1);
            restart();
        endfunction

        function void restart();
            foreach (held[i]) held[i] = 0;
            col = 0;
            row = 0;
        endfunction

        function void set_level_reg(input t_cfg_reg idx, input logic [CFG_W-1:0] val);
            case (idx)
                REG_LEVEL_WIDTH: begin
                    width_reg = val;
                end
                REG_LEVEL_HEIGHT: begin
                    height_reg = val;
                end
            endcase
            restart();
        endfunction

        function void take_source_pixel(input t_pixel_in px);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned pix [4];
            int unsigned pair [4];
            int unsigned sum [4];
            bit          last_col;
            bit          last_row;
            bit          pair_ready;
            bit          emit;
            t_pixel_out  res;
            pixels_in++;
            w = clamp_dim(width_reg, MAX_WIDTH_DEF);
            h = clamp_dim(height_reg, MAX_HEIGHT);
            pix[0] = 32'(px.in_red);
            pix[1] = 32'(px.in_green);
            pix[2] = 32'(px.in_blue);
            pix[3] = 32'(px.in_alpha);
            last_col   = (col + 1 >= w);
            last_row   = (row + 1 >= h);
            pair_ready = 1'b1;
            emit       = 1'b0;
            for (int i = 0; i < 4; i++) begin
                if ((col & 1) != 0) begin
                    pair[i] = held[i] + pix[i];
                end else if (last_col) begin
                    pair[i] = 2 * pix[i];
                end else begin
                    held[i]    = pix[i];
                    pair_ready = 1'b0;
                end
            end
            if (pair_ready) begin
                c = col >> 1;
                for (int i = 0; i < 4; i++) begin
                    if ((row & 1) != 0) begin
                        sum[i] = int'(pair_line[c][i]) + pair[i];
                        emit   = 1'b1;
                    end else if (last_row) begin
                        sum[i] = 2 * pair[i];
                        emit   = 1'b1;
                    end else begin
                        pair_line[c][i] = PAIR_W'(pair[i]);
                    end
                end
            end
            if (emit) begin
                res.out_red    = CH_W'(sum[0] / 4);
                res.out_green  = CH_W'(sum[1] / 4);
                res.out_blue   = CH_W'(sum[2] / 4);
                res.out_alpha  = CH_W'(sum[3] / 4);
                res.level_done = last_col && last_row;
                pending_mip.insert(pending_mip.size(), res);
            end
            col++;
            if (col >= w) begin
                col = 0;
                row++;
                if (row >= h) row = 0;
            end
        endfunction

        function void compare(input string field, input logic [CH_W-1:0] want,
                              input logic [CH_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_mip_pixel(input t_pixel_out got);
            t_pixel_out want;
            pixels_out++;
            if (pending_mip.size() == 0) begin
                $error("output transaction with no pixel expected: %h", got);
                errors++;
                return;
            end
            want = pending_mip.pop_front();
            compare("out_red", want.out_red, got.out_red);
            compare("out_green", want.out_green, got.out_green);
            compare("out_blue", want.out_blue, got.out_blue);
            compare("out_alpha", want.out_alpha, got.out_alpha);
            compare("level_done", CH_W'(want.level_done), CH_W'(got.level_done));
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    t_pixel_in            i_data;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    t_pixel_out           o_data;

    box_filter_board board = new();
    bit              source_gaps;
    bit              sink_stalls;
    int              stall_left = 0;
    int              quiet_cycles = 0;
    int              size_settings = 0;
    int              corner_k = 0;

    rgba8_mip_box_downsample dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    always @(posedge i_clk) begin
        if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            stall_left <= 0;
            i_ready    <= 1'b1;
        end else if (sink_stalls && $urandom_range(0, 99) < 20) begin
            stall_left <= idle_len();
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) board.check_mip_pixel(o_data);
        if (i_rst_n && i_valid && o_ready) board.take_source_pixel(i_data);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("rgba8_mip_box_downsample_test: errors");
            $finish;
        end
    end

    function automatic t_pixel_in random_pixel();
        return t_pixel_in'($urandom);
    endfunction

    function automatic t_pixel_in corner_pixel(input int k);
        if (k >= 9 && k < 13) return '1;
        if (k >= 13) return random_pixel();
        case (k % 4)
            0: return '0;
            1: return '1;
            2: return {8'h55, 8'hAA, 8'h0F, 8'hF0};
            default: return {8'hAA, 8'h55, 8'hF0, 8'h0F};
        endcase
    endfunction

    task automatic send_pixel(input t_pixel_in px);
        int gap;
        gap = (source_gaps && $urandom_range(0, 99) < 30) ? idle_len() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= px;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_mip.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic set_level_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_LEVEL_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        board.set_level_reg(REG_LEVEL_WIDTH, w);
        i_cfg_idx  <= REG_LEVEL_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        board.set_level_reg(REG_LEVEL_HEIGHT, h);
        i_cfg_we <= 1'b0;
        size_settings++;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input int count, input bit corners);
        int k;
        drain();
        set_level_size(w, h);
        source_gaps = ($urandom_range(0, 3) != 0);
        sink_stalls = ($urandom_range(0, 3) != 0);
        for (k = 0; k < count; k++) begin
            if (corners) begin
                send_pixel(corner_pixel(corner_k));
                corner_k++;
            end else begin
                send_pixel(random_pixel());
            end
        end
    endtask

    function automatic logic [CFG_W-1:0] random_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) return '0;
        if (r < 85) return CFG_W'($urandom_range(1, 12));
        return CFG_W'($urandom_range(13, 40));
    endfunction

    initial begin
        int               sent;
        int               count;
        int unsigned      area;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_LEVEL_WIDTH;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_data     = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_phase(3, 3, 9, 1'b1);
        run_phase(2, 2, 8, 1'b1);
        run_phase(0, 0, 3, 1'b1);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            w    = random_dim();
            h    = random_dim();
            area = clamp_dim(w, MAX_WIDTH_DEF) * clamp_dim(h, MAX_HEIGHT);
            if ($urandom_range(0, 6) == 0) begin
                count = $urandom_range(1, 2 * area);
            end else begin
                count = area * $urandom_range(1, 3);
            end
            if (count > RANDOM_ITEMS - sent) begin
                count = RANDOM_ITEMS - sent;
            end
            run_phase(w, h, count, 1'b0);
            sent += count;
        end

        run_phase(161, 2, 322, 1'b0);
        run_phase(8191, 1, 100, 1'b0);
        run_phase(4095, 3, 40, 1'b0);
        run_phase(0, 8191, 60, 1'b0);
        drain();

        $display("Checked %0d mip pixels from %0d source pixels over %0d size settings,",
                 board.pixels_out, board.pixels_in, size_settings);
        $display("from 1x1 to 4096 wide or tall, odd edges and cut-off levels included.");
        if (board.errors == 0 && board.pending_mip.size() == 0) begin
            $display("rgba8_mip_box_downsample_test: clean");
        end else begin
            $display("rgba8_mip_box_downsample_test: errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/mipds_pkg.sv
hw/rtl/mipds_line_ram.sv
hw/rtl/rgba8_mip_box_downsample.sv
hw/rtl/mipds_checker.sv
tb/rgba8_mip_box_downsample_test.sv
